FILE: rtl/vsg_pkg.sv
// ----------------------------------------------------------------------------
// vsg_pkg
// shared types, register codes and defaults for the scanline timing generator
// ----------------------------------------------------------------------------
package vsg_pkg;

    localparam int COLOR_BITS_DEF = 14;
    localparam int COUNT_BITS_DEF = 11;

    localparam int PIXEL_BITS = 14;
    localparam int WORD_BITS  = 16;
    localparam int X_BITS     = 10;
    localparam int Y_BITS     = 11;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int DIV_BITS      = 4;
    localparam int REP_BITS      = 3;

    localparam logic [Y_BITS-1:0]   ROW_MAX  = '1;
    localparam logic [DIV_BITS-1:0] DIV_MAX  = 4'd8;
    localparam int HSYNC_BIT = 14;
    localparam int VSYNC_BIT = 15;

    localparam logic [7:0]  H_FRONT_RST   = 8'd8;
    localparam logic [7:0]  H_SYNC_RST    = 8'd48;
    localparam logic [7:0]  H_BACK_RST    = 8'd26;
    localparam logic [9:0]  X_RES_RST     = 10'd320;
    localparam logic [23:0] V_PORCHES_RST = 24'h1F020B;
    localparam logic [10:0] V_LINES_RST   = 11'd480;
    localparam logic [3:0]  V_DIVIDER_RST = 4'd1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_H_FRONT   = 3'd0,
        CFG_H_SYNC    = 3'd1,
        CFG_H_BACK    = 3'd2,
        CFG_X_RES     = 3'd3,
        CFG_V_PORCHES = 3'd4,
        CFG_V_LINES   = 3'd5,
        CFG_V_DIVIDER = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]  h_front;
        logic [7:0]  h_sync;
        logic [7:0]  h_back;
        logic [9:0]  x_res;
        logic [23:0] v_porches;
        logic [10:0] v_lines;
        logic [3:0]  v_divider;
    } t_cfg;

    typedef struct packed {
        logic [WORD_BITS-1:0] out_word;
        logic [X_BITS-1:0]    pixel_x;
        logic [Y_BITS-1:0]    pixel_y;
        logic                 pixel_used;
        logic                 line_end;
    } t_result;

endpackage

FILE: rtl/vsg_cfg_regs.sv
// ----------------------------------------------------------------------------
// vsg_cfg_regs
// timing register file, written through the configuration channel
// ----------------------------------------------------------------------------
module vsg_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vsg_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [vsg_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output vsg_pkg::t_cfg                       o_cfg
);

    vsg_pkg::t_cfg r_cfg;
    vsg_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (vsg_pkg::t_cfg_index'(i_cfg_index))
                vsg_pkg::CFG_H_FRONT:   n_cfg.h_front   = i_cfg_data[7:0];
                vsg_pkg::CFG_H_SYNC:    n_cfg.h_sync    = i_cfg_data[7:0];
                vsg_pkg::CFG_H_BACK:    n_cfg.h_back    = i_cfg_data[7:0];
                vsg_pkg::CFG_X_RES:     n_cfg.x_res     = i_cfg_data[9:0];
                vsg_pkg::CFG_V_PORCHES: n_cfg.v_porches = i_cfg_data[23:0];
                vsg_pkg::CFG_V_LINES:   n_cfg.v_lines   = i_cfg_data[10:0];
                vsg_pkg::CFG_V_DIVIDER: n_cfg.v_divider = i_cfg_data[3:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h_front   <= vsg_pkg::H_FRONT_RST;
            r_cfg.h_sync    <= vsg_pkg::H_SYNC_RST;
            r_cfg.h_back    <= vsg_pkg::H_BACK_RST;
            r_cfg.x_res     <= vsg_pkg::X_RES_RST;
            r_cfg.v_porches <= vsg_pkg::V_PORCHES_RST;
            r_cfg.v_lines   <= vsg_pkg::V_LINES_RST;
            r_cfg.v_divider <= vsg_pkg::V_DIVIDER_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/vsg_timing.sv
// ----------------------------------------------------------------------------
// vsg_timing
// slot, line and row counters and the per-slot output word
// ----------------------------------------------------------------------------
module vsg_timing #(
    parameter int COLOR_BITS = vsg_pkg::COLOR_BITS_DEF,
    parameter int COUNT_BITS = vsg_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [vsg_pkg::PIXEL_BITS-1:0]   i_pixel_color,
    input  vsg_pkg::t_cfg                    i_cfg,
    output vsg_pkg::t_result                 o_result
);

    localparam int SW = (COUNT_BITS + 1 > 13) ? COUNT_BITS + 1 : 13;

    logic [COUNT_BITS-1:0]            r_slot_count, n_slot_count;
    logic [COUNT_BITS-1:0]            r_line_count, n_line_count;
    logic [vsg_pkg::Y_BITS-1:0]       r_row_index,  n_row_index;
    logic [vsg_pkg::REP_BITS-1:0]     r_row_repeat, n_row_repeat;

    logic [7:0]                       vf, vs, vb;
    logic [SW-1:0]                    hback_start, hactive, htotal;
    logic [SW-1:0]                    vsync_end, vstart, vtotal;
    logic [SW-1:0]                    slot_ext, line_ext, px_full;
    logic [vsg_pkg::DIV_BITS-1:0]     div;
    logic [15:0]                      row_need;
    logic                             vsync_on, hsync_on, line_active, used;
    logic                             lend, fend;
    logic [vsg_pkg::PIXEL_BITS-1:0]   color;

    always_comb begin
        vf = i_cfg.v_porches[7:0];
        vs = i_cfg.v_porches[15:8];
        vb = i_cfg.v_porches[23:16];

        hback_start = SW'(i_cfg.h_front) + SW'(i_cfg.h_sync);
        hactive     = hback_start + SW'(i_cfg.h_back);
        htotal      = hactive + SW'(i_cfg.x_res);
        vsync_end   = SW'(vf) + SW'(vs);
        vstart      = vsync_end + SW'(vb);
        vtotal      = vstart + SW'(i_cfg.v_lines);

        slot_ext = SW'(r_slot_count);
        line_ext = SW'(r_line_count);

        // divider of zero acts as one, above eight acts as eight
        if (i_cfg.v_divider == '0) begin
            div = vsg_pkg::DIV_BITS'(1);
        end else if (i_cfg.v_divider > vsg_pkg::DIV_MAX) begin
            div = vsg_pkg::DIV_MAX;
        end else begin
            div = i_cfg.v_divider;
        end

        // row shown while row_index < v_lines / div, i.e. (row_index + 1) * div <= v_lines
        row_need = (16'(r_row_index) + 16'd1) * 16'(div);

        vsync_on    = (line_ext >= SW'(vf)) && (line_ext < vsync_end);
        hsync_on    = (slot_ext >= SW'(i_cfg.h_front)) && (slot_ext < hback_start);
        line_active = (line_ext >= vstart) && (row_need <= 16'(i_cfg.v_lines));
        used        = line_active && (slot_ext >= hactive);
        px_full     = slot_ext - hactive;

        color = used ? vsg_pkg::PIXEL_BITS'(i_pixel_color[COLOR_BITS-1:0]) : '0;

        lend = (slot_ext + SW'(1) >= htotal) || (r_slot_count == '1);
        fend = (line_ext + SW'(1) >= vtotal) || (r_line_count == '1);

        o_result.out_word   = {~vsync_on, ~hsync_on, color};
        o_result.pixel_x    = used ? px_full[vsg_pkg::X_BITS-1:0] : '0;
        o_result.pixel_y    = used ? r_row_index : '0;
        o_result.pixel_used = used;
        o_result.line_end   = lend;

        n_slot_count = r_slot_count;
        n_line_count = r_line_count;
        n_row_index  = r_row_index;
        n_row_repeat = r_row_repeat;
        if (i_accept) begin
            if (lend) begin
                n_slot_count = '0;
                if (fend) begin
                    n_line_count = '0;
                    n_row_index  = '0;
                    n_row_repeat = '0;
                end else begin
                    if (line_ext >= vstart) begin
                        if (vsg_pkg::DIV_BITS'(r_row_repeat) + vsg_pkg::DIV_BITS'(1) >= div) begin
                            n_row_repeat = '0;
                            if (r_row_index != vsg_pkg::ROW_MAX) begin
                                n_row_index = r_row_index + vsg_pkg::Y_BITS'(1);
                            end
                        end else begin
                            n_row_repeat = r_row_repeat + vsg_pkg::REP_BITS'(1);
                        end
                    end
                    n_line_count = r_line_count + COUNT_BITS'(1);
                end
            end else begin
                n_slot_count = r_slot_count + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_line_count <= '0;
            r_row_index  <= '0;
            r_row_repeat <= '0;
        end else begin
            r_slot_count <= n_slot_count;
            r_line_count <= n_line_count;
            r_row_index  <= n_row_index;
            r_row_repeat <= n_row_repeat;
        end
    end

    a_line_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.line_end) |=> (r_slot_count == '0))
        else $error("slot counter did not restart after line end");

    a_active_no_hsync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.pixel_used |-> o_result.out_word[vsg_pkg::HSYNC_BIT])
        else $error("hsync asserted on an active slot");

    a_blank_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.pixel_used |-> (o_result.out_word[vsg_pkg::PIXEL_BITS-1:0] == '0))
        else $error("colour not blanked outside the active area");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_slot_count) && $stable(r_line_count))
        else $error("counters moved without a transaction");

endmodule

FILE: rtl/vsg_out_skid.sv
// ----------------------------------------------------------------------------
// vsg_out_skid
// output register with one skid entry so one more input is taken when output stalls
// ----------------------------------------------------------------------------
module vsg_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_accept,
    input  vsg_pkg::t_result   i_result,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vsg_pkg::t_result   o_result
);

    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    vsg_pkg::t_result r_out, n_out;
    vsg_pkg::t_result r_skid, n_skid;
    logic             accept;

    assign accept      = i_in_valid && !r_skid_valid;
    assign o_accept    = accept;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_result;
                n_out_valid = accept;
            end
        end else if (accept) begin
            // output held, park the new transaction
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("transaction lost while output stalled");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (!r_skid_valid && r_out_valid))
        else $error("skid entry not moved to output");

endmodule

FILE: rtl/vga_scanline_timing_generator_top.sv
// ----------------------------------------------------------------------------
// vga_scanline_timing_generator_top
// Turns a stream of pixel colors into display words with hsync and vsync.
// Each input transaction is one output pixel slot; the block returns one word
// per slot along with the frame column and row that the slot shows, so the
// source can fetch the next color. One transaction is accepted every clock
// while o_in_stall is low; its result, set by the slot, line and row counters
// that advance once per transaction, is registered in the output register or,
// while the output stalls, in a single skid entry that holds one more transaction.
// Timing registers change on the configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module vga_scanline_timing_generator_top #(
    parameter int COLOR_BITS = vsg_pkg::COLOR_BITS_DEF,
    parameter int COUNT_BITS = vsg_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [vsg_pkg::PIXEL_BITS-1:0]    i_pixel_color,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vsg_pkg::WORD_BITS-1:0]     o_out_word,
    output logic [vsg_pkg::X_BITS-1:0]        o_pixel_x,
    output logic [vsg_pkg::Y_BITS-1:0]        o_pixel_y,
    output logic                              o_pixel_used,
    output logic                              o_line_end,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vsg_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [vsg_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    vsg_pkg::t_cfg    cfg;
    vsg_pkg::t_result slot_result;
    vsg_pkg::t_result out_result;
    logic             accept;

    vsg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vsg_timing #(
        .COLOR_BITS (COLOR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_timing (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel_color (i_pixel_color),
        .i_cfg         (cfg),
        .o_result      (slot_result)
    );

    vsg_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .i_result    (slot_result),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_out_word   = out_result.out_word;
    assign o_pixel_x    = out_result.pixel_x;
    assign o_pixel_y    = out_result.pixel_y;
    assign o_pixel_used = out_result.pixel_used;
    assign o_line_end   = out_result.line_end;

endmodule
